// ===== src/hdlc_byte_deframer_crc16_assert.svh =====
// Assertion macros shared by the deframer queue and back modules.
// Needs nothing else; the modules include it by its bare file name.
`ifndef HDLC_BYTE_DEFRAMER_CRC16_ASSERT_SVH
`define HDLC_BYTE_DEFRAMER_CRC16_ASSERT_SVH

`ifndef SYNTHESIS
`define HDLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define HDLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define HDLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HDLC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/hdlc_dfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the HDLC deframer.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package hdlc_dfr_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  // Wide enough to hold the incremented count before the overflow check.
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ITEM_DATA,
    ITEM_CLOSE
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       abort;
    logic [7:0] data;
  } queue_item_t;

  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BADCRC   = 3'd2,
    ST_ABORT    = 3'd3,
    ST_OVERFLOW = 3'd4
  } frame_status_t;

  // Reflected CRC-16 (polynomial 0x8408), one byte, table-free form.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

`default_nettype wire

// ===== src/hdlc_dfr_front.sv =====
// Input side of the deframer: accepts raw bytes, removes escapes and
// classifies each byte as data or frame close. Uses hdlc_dfr_pkg.
`default_nettype none

module hdlc_dfr_front
  import hdlc_dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output queue_item_t      q_item
);

  logic escape_r, escape_nxt;
  logic accept;
  logic is_flag, is_esc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_flag  = (in_rx_byte == FLAG_BYTE);
  assign is_esc   = (in_rx_byte == ESC_BYTE);

  // An escape byte only arms the XOR (or the abort mark on a flag) for the next byte and queues nothing.
  assign q_push = accept && !is_esc;

  always_comb begin
    q_item.kind  = is_flag ? ITEM_CLOSE : ITEM_DATA;
    q_item.abort = escape_r;
    q_item.data  = escape_r ? (in_rx_byte ^ ESC_XOR) : in_rx_byte;
  end

  always_comb begin
    escape_nxt = escape_r;
    if (accept) begin
      escape_nxt = is_esc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
    end else begin
      escape_r <= escape_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hdlc_dfr_fifo.sv =====
// Short queue between the front and back of the deframer.
// Holds classified items; uses hdlc_dfr_pkg and the assertion macros.
`default_nettype none
`include "hdlc_byte_deframer_crc16_assert.svh"

module hdlc_dfr_fifo
  import hdlc_dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire queue_item_t push_item,
  output logic             full,
  input  wire logic        pop,
  output logic             head_valid,
  output queue_item_t      head_item
);

  queue_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `HDLC_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !full)
  `HDLC_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, head_valid)
  `HDLC_ASSERT_NXT(a_fill_tracks_pops, clk, rst_n, pop && !push, !full)

endmodule

`default_nettype wire

// ===== src/hdlc_dfr_back.sv =====
// Back side of the deframer: byte count, running CRC, the two held bytes
// and the output register. Uses hdlc_dfr_pkg and the assertion macros.
`default_nettype none
`include "hdlc_byte_deframer_crc16_assert.svh"

module hdlc_dfr_back
  import hdlc_dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire queue_item_t head_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_frame_status,
  output logic             out_frame_last
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  frame_status_t    out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             have_two;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && out_free;
  assign have_two = (cnt_r >= CNT_W'(2));
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (pop) begin
      if (head_item.kind == ITEM_CLOSE) begin
        if (have_two) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          if (head_item.abort) begin
            out_status_nxt = ST_ABORT;
          end else if (crc_r == {newer_r, older_r}) begin
            out_status_nxt = ST_GOOD;
          end else begin
            out_status_nxt = ST_BADCRC;
          end
        end
        cnt_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        // The byte leaving the two-byte hold is payload and enters the CRC.
        if (have_two) begin
          crc_nxt        = crc16_byte(crc_r, older_r);
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = older_r;
          out_status_nxt = ST_PAYLOAD;
          out_last_nxt   = 1'b0;
        end
        older_nxt = newer_r;
        newer_nxt = head_item.data;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_FRAME_BYTES)) begin
          cnt_nxt        = '0;
          crc_nxt        = CRC_INIT;
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = 8'h00;
          out_status_nxt = ST_OVERFLOW;
          out_last_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    older_r      <= older_nxt;
    newer_r      <= newer_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_status = out_status_r;
  assign out_frame_last   = out_last_r;

  `HDLC_ASSERT_IMP(a_cnt_below_max, clk, rst_n, 1'b1, cnt_r < CNT_W'(MAX_FRAME_BYTES))
  `HDLC_ASSERT_IMP(a_last_is_status, clk, rst_n, out_valid_r,
                   out_last_r == (out_status_r != ST_PAYLOAD))
  `HDLC_ASSERT_IMP(a_no_pop_while_held, clk, rst_n, out_valid_r && out_stall, !pop)

endmodule

`default_nettype wire

// ===== src/hdlc_byte_deframer_crc16.sv =====
// HDLC byte deframer with CRC-16 check, one received byte per beat.
// Input: in_valid / in_stall / in_rx_byte carry raw bytes from the line.
// Output: out_valid / out_stall carry one result per beat: a payload byte
// (out_frame_status 0, out_frame_last 0) or an end-of-frame status
// (1 good, 2 crc error, 3 aborted by escape, 4 overflow; out_frame_last 1).
// A beat moves on a rising edge with valid high and stall low.
// Throughput: one input beat per cycle, sustained, while the output drains.
// Each accepted input beat but an escape byte is written into the queue, and
// its result is registered in the output register when the back end pops
// it; payload bytes trail the line by two bytes, because the last two bytes
// of each frame are its CRC. Escape bytes and flags closing a frame shorter
// than two bytes yield no result.
// A two-entry queue between the unstuffing front and the frame back end
// lets either side stall alone; in_stall rises only when it is full.
// Reset (synchronous, rst_n low) empties the queue and output register and
// starts a fresh frame with the CRC at its initial value.
// Uses hdlc_dfr_pkg and the front, queue and back modules.
`default_nettype none

module hdlc_byte_deframer_crc16
  import hdlc_dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic [2:0]      out_frame_status,
  output logic            out_frame_last
);

  logic        q_full;
  logic        q_push;
  queue_item_t q_item;
  logic        q_pop;
  logic        q_head_valid;
  queue_item_t q_head_item;

  hdlc_dfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  hdlc_dfr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  hdlc_dfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_item        (q_head_item),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_frame_last   (out_frame_last)
  );

endmodule

`default_nettype wire

// ===== tb/tb_hdlc_byte_deframer_crc16.sv =====
// Self-checking testbench for hdlc_byte_deframer_crc16: line bytes in, payload and status out.
// Depends on hdlc_dfr_pkg and the deframer RTL; a built-in byte-level predictor supplies
// the expected results, and a random driver and monitor exercise both handshakes.
module tb_hdlc_byte_deframer_crc16;
  import hdlc_dfr_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          RST_CYCLES   = 7;
  localparam int          LINE_ITEMS   = 1800;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          IDLE_PCT     = 24;
  localparam int          CALM_FROM    = 250;
  localparam int          CALM_TO      = 1250;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 80;
  localparam logic [15:0] CRC_POLY     = 16'h8408;

  localparam int FRAME_GOOD   = 0;
  localparam int FRAME_BADCRC = 1;
  localparam int FRAME_ABORT  = 2;

  typedef struct {
    logic [7:0]    payload;
    frame_status_t status;
    logic          last;
  } deframe_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic [2:0] out_frame_status;
  logic       out_frame_last;

  logic [7:0]      line_bytes[$];
  deframe_result_t expected_results[$];
  int              error_count = 0;
  int              cycle_count = 0;
  int              hold_left = 0;

  // Predictor state, mirroring the deframer's frame context.
  logic        esc_pending = 1'b0;
  int          frame_len = 0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [7:0]  held_old = 8'h00;
  logic [7:0]  held_new = 8'h00;

  hdlc_byte_deframer_crc16 DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_frame_last   (out_frame_last)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Bitwise reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_x25_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void add_line_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  function automatic void add_expected(input deframe_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void push_status(input frame_status_t st);
    deframe_result_t r;
    r.payload = 8'h00;
    r.status  = st;
    r.last    = 1'b1;
    add_expected(r);
  endfunction

  // Advances the predictor by one accepted line byte.
  function automatic void deframe_byte(input logic [7:0] rx);
    deframe_result_t r;
    logic [7:0]      b;
    b = rx;
    if (b == FLAG_BYTE) begin
      if (frame_len >= 2) begin
        if (esc_pending) push_status(ST_ABORT);
        else if (frame_crc == {held_new, held_old}) push_status(ST_GOOD);
        else push_status(ST_BADCRC);
      end
      esc_pending = 1'b0;
      frame_len   = 0;
      frame_crc   = CRC_INIT;
      return;
    end
    if (b == ESC_BYTE) begin
      esc_pending = 1'b1;
      return;
    end
    if (esc_pending) begin
      esc_pending = 1'b0;
      b = b ^ ESC_XOR;
    end
    // The oldest held byte is known not to be CRC once a third byte arrives.
    if (frame_len >= 2) begin
      frame_crc = crc_x25_update(frame_crc, held_old);
      r.payload = held_old;
      r.status  = ST_PAYLOAD;
      r.last    = 1'b0;
      if (frame_len + 1 < MAX_FRAME_BYTES) add_expected(r);
    end
    held_old  = held_new;
    held_new  = b;
    frame_len = frame_len + 1;
    if (frame_len >= MAX_FRAME_BYTES) begin
      frame_len = 0;
      frame_crc = CRC_INIT;
      push_status(ST_OVERFLOW);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[6];
    specials = '{FLAG_BYTE, ESC_BYTE, 8'h5E, 8'h5D, 8'h00, 8'hFF};
    if ($urandom_range(99) < 20) return specials[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  // Appends CRC, stuffs and closes one frame, with a flipped bit or an abort if asked.
  task automatic add_frame(input logic [7:0] body[$], input int flavor);
    logic [15:0] crc;
    logic [7:0]  full[$];
    logic [7:0]  b;
    int          k;
    crc  = CRC_INIT;
    full = body;
    foreach (body[i]) crc = crc_x25_update(crc, body[i]);
    full.insert(full.size(), crc[7:0]);
    full.insert(full.size(), crc[15:8]);
    if (flavor == FRAME_BADCRC) begin
      k = $urandom_range(full.size() - 1);
      full[k] = full[k] ^ (8'h01 << $urandom_range(7));
    end
    foreach (full[i]) begin
      b = full[i];
      // Any byte may be escaped as long as its escaped form is not itself special.
      if (b == FLAG_BYTE || b == ESC_BYTE ||
          ($urandom_range(99) < 5 && (b ^ ESC_XOR) != FLAG_BYTE && (b ^ ESC_XOR) != ESC_BYTE))
      begin
        if ($urandom_range(99) < 10) add_line_byte(ESC_BYTE);
        add_line_byte(ESC_BYTE);
        add_line_byte(b ^ ESC_XOR);
      end else begin
        add_line_byte(b);
      end
    end
    if (flavor == FRAME_ABORT) add_line_byte(ESC_BYTE);
    add_line_byte(FLAG_BYTE);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Sender: keeps a stalled beat steady and predicts each accepted byte.
  always @(posedge clk) begin
    logic skip;
    skip = (cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
           ($urandom_range(99) < IDLE_PCT);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (line_bytes.size() != 0 && !skip) begin
          in_valid   <= 1'b1;
          in_rx_byte <= line_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == HOLD_AT) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver: checks each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    deframe_result_t want;
    logic            skip;
    skip = (cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
           ($urandom_range(99) < IDLE_PCT);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat payload=%02h status=%0d last=%0d",
                                    out_payload_byte, out_frame_status, out_frame_last));
        end else begin
          want = expected_results.pop_front();
          if (out_payload_byte != want.payload)
            report_mismatch($sformatf("payload %02h, expected %02h",
                                      out_payload_byte, want.payload));
          if (out_frame_status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_frame_status, want.status));
          if (out_frame_last != want.last)
            report_mismatch($sformatf("last %0d, expected %0d",
                                      out_frame_last, want.last));
        end
      end
      out_stall <= (hold_left != 0) || skip;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [7:0] body[$];
    int         frame_no;
    int         long_left;
    int         pick;

    // Directed: empty and one-byte frames, stuffing, abort, repeated escape, bad CRC.
    add_line_byte(FLAG_BYTE);
    add_line_byte(8'h55);
    add_line_byte(FLAG_BYTE);
    body = {8'h00, 8'hFF};
    add_frame(body, FRAME_GOOD);
    body = {FLAG_BYTE, ESC_BYTE, 8'h5E};
    add_frame(body, FRAME_GOOD);
    add_line_byte(8'h11);
    add_line_byte(8'h22);
    add_line_byte(ESC_BYTE);
    add_line_byte(FLAG_BYTE);
    add_line_byte(8'hA5);
    add_line_byte(ESC_BYTE);
    add_line_byte(ESC_BYTE);
    add_line_byte(8'h5E);
    add_line_byte(FLAG_BYTE);
    body = {};
    add_frame(body, FRAME_BADCRC);

    // Random: mostly well-formed frames, a few just under, at and past the length limit.
    frame_no  = 0;
    long_left = 3;
    while (line_bytes.size() < LINE_ITEMS) begin
      body.delete();
      if (frame_no % 15 == 10 && long_left > 0) begin
        repeat ((long_left == 3) ? MAX_FRAME_BYTES - 3 :
                (long_left == 2) ? MAX_FRAME_BYTES - 2 :
                $urandom_range(MAX_FRAME_BYTES - 1, MAX_FRAME_BYTES + 44))
          body.insert(body.size(), pick_byte());
        add_frame(body, FRAME_GOOD);
        long_left--;
      end else begin
        pick = $urandom_range(99);
        repeat ($urandom_range(24)) body.insert(body.size(), pick_byte());
        if (pick < 68) add_frame(body, FRAME_GOOD);
        else if (pick < 80) add_frame(body, FRAME_BADCRC);
        else if (pick < 88) add_frame(body, FRAME_ABORT);
        else repeat ($urandom_range(1, 6)) add_line_byte(pick_byte());
      end
      frame_no++;
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    wait (rst_n && line_bytes.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
